FILE: rtl/x25cs_pkg.sv
// ----------------------------------------------------------------------------
// x25cs_pkg
// Shared types, codes and helpers of the X.25 channel send control block.
// ----------------------------------------------------------------------------
package x25cs_pkg;

  // Sequence numbering
  localparam int unsigned SEQ_MODULUS = 8;
  localparam int unsigned SEQ_W       = $clog2(SEQ_MODULUS);
  typedef logic [SEQ_W-1:0] seq_t;

  // Front-to-back command queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 48;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register reset values
  localparam logic [2:0]  WINDOW_SIZE_RST   = 3'd2;
  localparam logic [15:0] CALL_TIMER_RST    = 16'd200;
  localparam logic [15:0] CLEAR_TIMER_RST   = 16'd180;
  localparam logic [15:0] RESTART_TIMER_RST = 16'd180;

  typedef enum logic [1:0] {
    REG_WINDOW_SIZE   = 2'd0,
    REG_CALL_TIMER    = 2'd1,
    REG_CLEAR_TIMER   = 2'd2,
    REG_RESTART_TIMER = 2'd3
  } reg_idx_e;

  // Packet types; all unassigned codes collapse into PKT_OTHER
  typedef enum logic [3:0] {
    PKT_CALL        = 4'd0,
    PKT_ACCEPTED    = 4'd1,
    PKT_CLEAR       = 4'd2,
    PKT_CLEARCONF   = 4'd3,
    PKT_DATA        = 4'd4,
    PKT_INTR        = 4'd5,
    PKT_INTRCONF    = 4'd6,
    PKT_RR          = 4'd7,
    PKT_RNR         = 4'd8,
    PKT_RESET       = 4'd9,
    PKT_RESETCONF   = 4'd10,
    PKT_RESTART     = 4'd11,
    PKT_RESTARTCONF = 4'd12,
    PKT_OTHER       = 4'd15
  } pkt_e;

  typedef enum logic [2:0] {
    CS_READY  = 3'd0,
    CS_RCALL  = 3'd1,
    CS_SCALL  = 3'd2,
    CS_DATA   = 3'd3,
    CS_RCLEAR = 3'd4,
    CS_SCLEAR = 3'd5
  } chan_state_e;

  typedef enum logic [1:0] {
    STS_SENT    = 2'd0,
    STS_DROPPED = 2'd1,
    STS_HELD    = 2'd2,
    STS_UPDATED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    STAMP_NONE  = 2'd0,
    STAMP_PR    = 2'd1,
    STAMP_PS_PR = 2'd2
  } stamp_e;

  typedef struct packed {
    logic [2:0]  window_size;
    logic [15:0] call_timer;
    logic [15:0] clear_timer;
    logic [15:0] restart_timer;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic       is_update;
    pkt_e       pkt;
    logic       from_template;
    logic       state_ok;
    logic [2:0] new_state;
    logic       peer_busy;
    logic [2:0] peer_window;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    stamp_e      stamp_kind;
    logic [2:0]  send_seq_stamp;
    logic [2:0]  recv_seq_stamp;
    logic        timer_reload;
    logic [15:0] timer_value;
    logic [2:0]  channel_state_out;
    logic [7:0]  retry_out;
    logic        window_closed;
    logic        intr_conf_pending;
    logic        reset_pending;
  } result_t;

  // Modular add of a sequence number and a window offset below the modulus
  function automatic seq_t seq_add(input seq_t a, input logic [2:0] b);
    logic [SEQ_W:0] sum;
    sum = {1'b0, a} + (SEQ_W+1)'(b);
    if (sum >= (SEQ_W+1)'(SEQ_MODULUS)) begin
      sum = sum - (SEQ_W+1)'(SEQ_MODULUS);
    end
    return sum[SEQ_W-1:0];
  endfunction

endpackage

FILE: rtl/x25_channel_send_control.sv
// ----------------------------------------------------------------------------
// x25_channel_send_control
// Send-side control of one X.25 logical channel, modulo-8 numbering.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the queue has room and returns one
// result item for each. An accepted item is classified into a two-entry queue
// and executed by the back end once the output register is empty or being read;
// its result passes the queue entry and then the output register. The input
// stays ready while the queue has room, so a stalled output absorbs two more
// items before the input stops. Registers are written over APB and must be
// written only while the block holds no items.
module x25_channel_send_control (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [3:0] packet_type, [4] from_template, [7:5] new_state, [8] peer_busy,
  // [11:9] peer_window, [15:12] zero
  input  logic [x25cs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] req_type
  input  logic                               s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [3:2] stamp_kind, [6:4] send_seq_stamp, [9:7] recv_seq_stamp,
  // [10] timer_reload, [26:11] timer_value, [29:27] channel_state_out,
  // [37:30] retry_out, [38] window_closed, [39] intr_conf_pending,
  // [40] reset_pending, [47:41] zero
  output logic [x25cs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [x25cs_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [x25cs_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [x25cs_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready
);

  x25cs_pkg::cfg_t    cfg;
  x25cs_pkg::cmd_t    push_cmd, head_cmd;
  x25cs_pkg::result_t res;
  logic               q_full, push, pop, q_valid;

  x25cs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  x25cs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  x25cs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  x25cs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res)
  );

  // pack result, first field lowest
  assign m_axis_tdata = {7'd0,
                         res.reset_pending,
                         res.intr_conf_pending,
                         res.window_closed,
                         res.retry_out,
                         res.channel_state_out,
                         res.timer_value,
                         res.timer_reload,
                         res.recv_seq_stamp,
                         res.send_seq_stamp,
                         res.stamp_kind,
                         res.status};

endmodule

FILE: rtl/x25cs_regs.sv
// ----------------------------------------------------------------------------
// x25cs_regs
// APB register file: window size and the three timer reload values.
// ----------------------------------------------------------------------------
module x25cs_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [x25cs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [x25cs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [x25cs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  output x25cs_pkg::cfg_t                     cfg_o
);

  x25cs_pkg::cfg_t     cfg_q, cfg_d;
  x25cs_pkg::reg_idx_e idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = x25cs_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        x25cs_pkg::REG_WINDOW_SIZE:   cfg_d.window_size   = pwdata[2:0];
        x25cs_pkg::REG_CALL_TIMER:    cfg_d.call_timer    = pwdata[15:0];
        x25cs_pkg::REG_CLEAR_TIMER:   cfg_d.clear_timer   = pwdata[15:0];
        x25cs_pkg::REG_RESTART_TIMER: cfg_d.restart_timer = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size   <= x25cs_pkg::WINDOW_SIZE_RST;
      cfg_q.call_timer    <= x25cs_pkg::CALL_TIMER_RST;
      cfg_q.clear_timer   <= x25cs_pkg::CLEAR_TIMER_RST;
      cfg_q.restart_timer <= x25cs_pkg::RESTART_TIMER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      x25cs_pkg::REG_WINDOW_SIZE:   prdata = {29'd0, cfg_q.window_size};
      x25cs_pkg::REG_CALL_TIMER:    prdata = {16'd0, cfg_q.call_timer};
      x25cs_pkg::REG_CLEAR_TIMER:   prdata = {16'd0, cfg_q.clear_timer};
      x25cs_pkg::REG_RESTART_TIMER: prdata = {16'd0, cfg_q.restart_timer};
      default:                      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/x25cs_front.sv
// ----------------------------------------------------------------------------
// x25cs_front
// Input side: unpacks and classifies items and pushes them into the queue.
// ----------------------------------------------------------------------------
module x25cs_front (
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [x25cs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tuser,
  input  logic                               q_full_i,
  output logic                               push_o,
  output x25cs_pkg::cmd_t                    cmd_o
);

  logic [3:0] ptype;

  assign s_axis_tready = ~q_full_i;
  assign push_o        = s_axis_tvalid & ~q_full_i;
  assign ptype         = s_axis_tdata[3:0];

  // classify packet type and check the update state
  always_comb begin
    cmd_o.is_update     = s_axis_tuser;
    cmd_o.from_template = s_axis_tdata[4];
    cmd_o.new_state     = s_axis_tdata[7:5];
    cmd_o.peer_busy     = s_axis_tdata[8];
    cmd_o.peer_window   = s_axis_tdata[11:9];
    cmd_o.state_ok      = (s_axis_tdata[7:5] <= 3'(x25cs_pkg::CS_SCLEAR));
    if (ptype <= 4'(x25cs_pkg::PKT_RESTARTCONF)) begin
      cmd_o.pkt = x25cs_pkg::pkt_e'(ptype);
    end else begin
      cmd_o.pkt = x25cs_pkg::PKT_OTHER;
    end
  end

endmodule

FILE: rtl/x25cs_queue.sv
// ----------------------------------------------------------------------------
// x25cs_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module x25cs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  x25cs_pkg::cmd_t  cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output x25cs_pkg::cmd_t  cmd_o
);

  localparam int unsigned Depth = x25cs_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = x25cs_pkg::QPTR_W;
  localparam int unsigned CntW  = x25cs_pkg::QCNT_W;

  x25cs_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/x25cs_back.sv
// ----------------------------------------------------------------------------
// x25cs_back
// Channel state and sequence counters; executes one item per cycle into the
// output register while that register is empty or being read.
// ----------------------------------------------------------------------------
module x25cs_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  x25cs_pkg::cfg_t                    cfg_i,
  input  logic                               q_valid_i,
  input  x25cs_pkg::cmd_t                    cmd_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output x25cs_pkg::result_t                 res_o
);

  x25cs_pkg::chan_state_e cs_q, cs_d;
  x25cs_pkg::seq_t        send_seq_q, send_seq_d;
  x25cs_pkg::seq_t        recv_seq_q, recv_seq_d;
  x25cs_pkg::seq_t        last_ack_q, last_ack_d;
  x25cs_pkg::seq_t        peer_win_q, peer_win_d;
  logic                   busy_q, busy_d;
  logic                   win_flag_q, win_flag_d;
  logic                   rst_flag_q, rst_flag_d;
  logic                   intr_flag_q, intr_flag_d;
  logic [7:0]             retry_q, retry_d;
  logic                   out_valid_q;
  x25cs_pkg::result_t     out_q, res_d;
  logic                   take;
  logic                   data_st;

  assign take    = q_valid_i & (~out_valid_q | m_axis_tready);
  assign pop_o   = take;
  assign data_st = (cs_q == x25cs_pkg::CS_DATA);

  // item execution
  always_comb begin
    cs_d        = cs_q;
    send_seq_d  = send_seq_q;
    recv_seq_d  = recv_seq_q;
    last_ack_d  = last_ack_q;
    peer_win_d  = peer_win_q;
    busy_d      = busy_q;
    win_flag_d  = win_flag_q;
    rst_flag_d  = rst_flag_q;
    intr_flag_d = intr_flag_q;
    retry_d     = retry_q;

    res_d                = '0;
    res_d.status         = x25cs_pkg::STS_SENT;
    res_d.stamp_kind     = x25cs_pkg::STAMP_NONE;

    if (cmd_i.is_update) begin
      if (cmd_i.state_ok) begin
        cs_d = x25cs_pkg::chan_state_e'(cmd_i.new_state);
      end
      busy_d     = cmd_i.peer_busy;
      peer_win_d = x25cs_pkg::seq_t'(cmd_i.peer_window);
      if (send_seq_q != x25cs_pkg::seq_add(peer_win_d, cfg_i.window_size)) begin
        win_flag_d = 1'b0;
      end
      res_d.status = x25cs_pkg::STS_UPDATED;
    end else if (!cmd_i.from_template && (busy_q || win_flag_q || rst_flag_q)) begin
      res_d.status = x25cs_pkg::STS_HELD;
    end else begin
      case (cmd_i.pkt)
        x25cs_pkg::PKT_CALL: begin
          if (cs_q == x25cs_pkg::CS_READY) begin
            cs_d               = x25cs_pkg::CS_SCALL;
            res_d.timer_reload = 1'b1;
            res_d.timer_value  = cfg_i.call_timer;
          end else begin
            res_d.status = x25cs_pkg::STS_DROPPED;
          end
        end
        x25cs_pkg::PKT_ACCEPTED: begin
          if (cs_q == x25cs_pkg::CS_RCALL) cs_d = x25cs_pkg::CS_DATA;
          else res_d.status = x25cs_pkg::STS_DROPPED;
        end
        x25cs_pkg::PKT_CLEAR: begin
          if (cs_q == x25cs_pkg::CS_RCALL || cs_q == x25cs_pkg::CS_SCALL ||
              cs_q == x25cs_pkg::CS_DATA) begin
            cs_d               = x25cs_pkg::CS_SCLEAR;
            retry_d            = 8'd1;
            res_d.timer_reload = 1'b1;
            res_d.timer_value  = cfg_i.clear_timer;
          end else if (cs_q == x25cs_pkg::CS_SCLEAR) begin
            // retry count saturates
            if (retry_q != 8'hFF) retry_d = retry_q + 8'd1;
            res_d.timer_reload = 1'b1;
            res_d.timer_value  = cfg_i.clear_timer;
          end else begin
            res_d.status = x25cs_pkg::STS_DROPPED;
          end
        end
        x25cs_pkg::PKT_CLEARCONF: begin
          if (cs_q == x25cs_pkg::CS_RCLEAR || cs_q == x25cs_pkg::CS_SCLEAR ||
              cs_q == x25cs_pkg::CS_READY) begin
            cs_d = x25cs_pkg::CS_READY;
          end else begin
            res_d.status = x25cs_pkg::STS_DROPPED;
          end
        end
        x25cs_pkg::PKT_DATA: begin
          if (data_st) begin
            res_d.stamp_kind     = x25cs_pkg::STAMP_PS_PR;
            res_d.send_seq_stamp = 3'(send_seq_q);
            res_d.recv_seq_stamp = 3'(recv_seq_q);
            last_ack_d           = recv_seq_q;
            send_seq_d           = x25cs_pkg::seq_add(send_seq_q, 3'd1);
            // window full once P(S) reaches the upper window edge
            if (send_seq_d == x25cs_pkg::seq_add(peer_win_q, cfg_i.window_size)) begin
              win_flag_d = 1'b1;
            end
          end else begin
            res_d.status = x25cs_pkg::STS_DROPPED;
          end
        end
        x25cs_pkg::PKT_INTR: begin
          if (data_st) intr_flag_d = 1'b1;
          else res_d.status = x25cs_pkg::STS_DROPPED;
        end
        x25cs_pkg::PKT_INTRCONF: begin
          if (!data_st) res_d.status = x25cs_pkg::STS_DROPPED;
        end
        x25cs_pkg::PKT_RR: begin
          if (data_st) begin
            recv_seq_d           = x25cs_pkg::seq_add(recv_seq_q, 3'd1);
            res_d.stamp_kind     = x25cs_pkg::STAMP_PR;
            res_d.recv_seq_stamp = 3'(recv_seq_d);
            last_ack_d           = recv_seq_d;
          end else begin
            res_d.status = x25cs_pkg::STS_DROPPED;
          end
        end
        x25cs_pkg::PKT_RNR: begin
          if (data_st) begin
            res_d.stamp_kind     = x25cs_pkg::STAMP_PR;
            res_d.recv_seq_stamp = 3'(recv_seq_q);
            last_ack_d           = recv_seq_q;
          end else begin
            res_d.status = x25cs_pkg::STS_DROPPED;
          end
        end
        x25cs_pkg::PKT_RESET: begin
          if (data_st) rst_flag_d = 1'b1;
          else res_d.status = x25cs_pkg::STS_DROPPED;
        end
        x25cs_pkg::PKT_RESETCONF: begin
          if (data_st) rst_flag_d = 1'b0;
          else res_d.status = x25cs_pkg::STS_DROPPED;
        end
        x25cs_pkg::PKT_RESTART: begin
          if (cs_q == x25cs_pkg::CS_READY) begin
            res_d.timer_reload = 1'b1;
            res_d.timer_value  = cfg_i.restart_timer;
          end else begin
            res_d.status = x25cs_pkg::STS_DROPPED;
          end
        end
        x25cs_pkg::PKT_RESTARTCONF: begin
          if (cs_q != x25cs_pkg::CS_READY) res_d.status = x25cs_pkg::STS_DROPPED;
        end
        default: res_d.status = x25cs_pkg::STS_DROPPED;
      endcase
    end

    // state after the item
    res_d.channel_state_out = cs_d;
    res_d.retry_out         = retry_d;
    res_d.window_closed     = win_flag_d;
    res_d.intr_conf_pending = intr_flag_d;
    res_d.reset_pending     = rst_flag_d;
  end

  // channel state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q        <= x25cs_pkg::CS_READY;
      send_seq_q  <= '0;
      recv_seq_q  <= '0;
      last_ack_q  <= '0;
      peer_win_q  <= '0;
      busy_q      <= 1'b0;
      win_flag_q  <= 1'b0;
      rst_flag_q  <= 1'b0;
      intr_flag_q <= 1'b0;
      retry_q     <= '0;
    end else if (take) begin
      cs_q        <= cs_d;
      send_seq_q  <= send_seq_d;
      recv_seq_q  <= recv_seq_d;
      last_ack_q  <= last_ack_d;
      peer_win_q  <= peer_win_d;
      busy_q      <= busy_d;
      win_flag_q  <= win_flag_d;
      rst_flag_q  <= rst_flag_d;
      intr_flag_q <= intr_flag_d;
      retry_q     <= retry_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign res_o         = out_q;

endmodule

FILE: rtl/x25cs_checker.sv
// ----------------------------------------------------------------------------
// x25cs_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module x25cs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [x25cs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic [1:0]  status;
  logic [1:0]  stamp;
  logic        reload;
  logic [15:0] tval;
  logic [2:0]  state;

  assign status = m_axis_tdata[1:0];
  assign stamp  = m_axis_tdata[3:2];
  assign reload = m_axis_tdata[10];
  assign tval   = m_axis_tdata[26:11];
  assign state  = m_axis_tdata[29:27];

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // held, dropped and update items carry no stamp and no timer load
  a_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status != 2'(x25cs_pkg::STS_SENT) |->
      stamp == 2'(x25cs_pkg::STAMP_NONE) && !reload && tval == 16'd0)
    else $error("action reported on an item that was not sent");

  // a timer load never comes with a sequence stamp
  a_reload_nostamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && reload |-> stamp == 2'(x25cs_pkg::STAMP_NONE))
    else $error("timer load together with a stamp");

  // stamped packets leave the channel in data transfer
  a_stamp_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && stamp != 2'(x25cs_pkg::STAMP_NONE) |->
      state == 3'(x25cs_pkg::CS_DATA))
    else $error("stamp outside data transfer");

endmodule

bind x25_channel_send_control x25cs_checker u_x25cs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the X.25 channel send control block. A cycle-free
// predictor of the channel tracks state, sequence counters, flags and
// register settings; every result item is compared field by field against
// the prediction made when its input item was accepted.
// ----------------------------------------------------------------------------
module tb_top;
  import x25cs_pkg::*;

  // Outgoing packet codes the package folds into one enum member
  localparam logic [3:0] PKT_SPARE_A = 4'd13;
  localparam logic [3:0] PKT_SPARE_B = 4'd14;
  // Channel state codes outside the legal range
  localparam logic [2:0] CS_BAD_LO = 3'd6;
  localparam logic [2:0] CS_BAD_HI = 3'd7;

  localparam int CLK_HALF    = 6;
  localparam int LIMIT_TICKS = 12 * 400000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic       req_type;
    logic [3:0] packet_type;
    logic       from_template;
    logic [2:0] new_state;
    logic       peer_busy;
    logic [2:0] peer_window;
  } chan_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  x25_channel_send_control uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Register shadow
  logic [2:0]  cfg_window  = WINDOW_SIZE_RST;
  logic [15:0] cfg_call    = CALL_TIMER_RST;
  logic [15:0] cfg_clear   = CLEAR_TIMER_RST;
  logic [15:0] cfg_restart = RESTART_TIMER_RST;

  // Channel shadow
  logic [2:0] ch_state      = CS_READY;
  seq_t       send_seq_q    = '0;
  seq_t       recv_seq_q    = '0;
  seq_t       peer_edge     = '0;
  logic       peer_busy_q   = 1'b0;
  logic       window_full   = 1'b0;
  logic       reset_pend    = 1'b0;
  logic       intr_wait     = 1'b0;
  logic [7:0] clear_retries = '0;

  result_t expected_results[$];
  int      fail_count      = 0;
  int      items_sent      = 0;
  int      results_checked = 0;
  int      settings_used   = 0;
  int      burst_left      = 0;

  // Channel behavior for one accepted item; advances the shadow state
  function automatic result_t predict_channel(input chan_item_t it);
    result_t    r;
    logic [2:0] cs;
    seq_t       win_limit;
    r  = '0;
    cs = ch_state;
    if (it.req_type) begin
      if (it.new_state <= CS_SCLEAR) ch_state = it.new_state;
      peer_busy_q = it.peer_busy;
      peer_edge   = it.peer_window;
      win_limit   = peer_edge + cfg_window;
      if (send_seq_q != win_limit) window_full = 1'b0;
      r.status = STS_UPDATED;
    end else if (!it.from_template && (peer_busy_q || window_full || reset_pend)) begin
      r.status = STS_HELD;
    end else begin
      r.status = STS_SENT;
      case (it.packet_type)
        PKT_CALL: begin
          if (cs == CS_READY) begin
            ch_state = CS_SCALL;
            r.timer_reload = 1'b1;
            r.timer_value  = cfg_call;
          end else r.status = STS_DROPPED;
        end
        PKT_ACCEPTED: begin
          if (cs == CS_RCALL) ch_state = CS_DATA;
          else r.status = STS_DROPPED;
        end
        PKT_CLEAR: begin
          if (cs == CS_RCALL || cs == CS_SCALL || cs == CS_DATA) begin
            ch_state       = CS_SCLEAR;
            clear_retries  = 8'd1;
            r.timer_reload = 1'b1;
            r.timer_value  = cfg_clear;
          end else if (cs == CS_SCLEAR) begin
            if (clear_retries != 8'hFF) clear_retries = clear_retries + 8'd1;
            r.timer_reload = 1'b1;
            r.timer_value  = cfg_clear;
          end else r.status = STS_DROPPED;
        end
        PKT_CLEARCONF: begin
          if (cs == CS_RCLEAR || cs == CS_SCLEAR || cs == CS_READY) ch_state = CS_READY;
          else r.status = STS_DROPPED;
        end
        PKT_DATA: begin
          if (cs == CS_DATA) begin
            r.stamp_kind     = STAMP_PS_PR;
            r.send_seq_stamp = send_seq_q;
            r.recv_seq_stamp = recv_seq_q;
            send_seq_q       = send_seq_q + 1'b1;
            win_limit        = peer_edge + cfg_window;
            if (send_seq_q == win_limit) window_full = 1'b1;
          end else r.status = STS_DROPPED;
        end
        PKT_INTR: begin
          if (cs == CS_DATA) intr_wait = 1'b1;
          else r.status = STS_DROPPED;
        end
        PKT_INTRCONF: begin
          if (cs != CS_DATA) r.status = STS_DROPPED;
        end
        PKT_RR: begin
          if (cs == CS_DATA) begin
            recv_seq_q       = recv_seq_q + 1'b1;
            r.stamp_kind     = STAMP_PR;
            r.recv_seq_stamp = recv_seq_q;
          end else r.status = STS_DROPPED;
        end
        PKT_RNR: begin
          if (cs == CS_DATA) begin
            r.stamp_kind     = STAMP_PR;
            r.recv_seq_stamp = recv_seq_q;
          end else r.status = STS_DROPPED;
        end
        PKT_RESET: begin
          if (cs == CS_DATA) reset_pend = 1'b1;
          else r.status = STS_DROPPED;
        end
        PKT_RESETCONF: begin
          if (cs == CS_DATA) reset_pend = 1'b0;
          else r.status = STS_DROPPED;
        end
        PKT_RESTART: begin
          if (cs == CS_READY) begin
            r.timer_reload = 1'b1;
            r.timer_value  = cfg_restart;
          end else r.status = STS_DROPPED;
        end
        PKT_RESTARTCONF: begin
          if (cs != CS_READY) r.status = STS_DROPPED;
        end
        default: r.status = STS_DROPPED;
      endcase
    end
    r.channel_state_out = ch_state;
    r.retry_out         = clear_retries;
    r.window_closed     = window_full;
    r.intr_conf_pending = intr_wait;
    r.reset_pending     = reset_pend;
    return r;
  endfunction

  function automatic void check_field(input string label, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      fail_count++;
    end
  endfunction

  // Scoreboard: log each accepted item, then check each accepted result item
  always @(posedge clk_i) begin : channel_scoreboard
    chan_item_t it;
    result_t    want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.req_type      = s_axis_tuser;
        it.packet_type   = s_axis_tdata[3:0];
        it.from_template = s_axis_tdata[4];
        it.new_state     = s_axis_tdata[7:5];
        it.peer_busy     = s_axis_tdata[8];
        it.peer_window   = s_axis_tdata[11:9];
        expected_results.push_back(predict_channel(it));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $display("%0t: result item with no expectation, expected none, actual %h",
                   $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, m_axis_tdata[1:0]);
          check_field("stamp_kind", want.stamp_kind, m_axis_tdata[3:2]);
          check_field("send_seq_stamp", want.send_seq_stamp, m_axis_tdata[6:4]);
          check_field("recv_seq_stamp", want.recv_seq_stamp, m_axis_tdata[9:7]);
          check_field("timer_reload", want.timer_reload, m_axis_tdata[10]);
          check_field("timer_value", want.timer_value, m_axis_tdata[26:11]);
          check_field("channel_state_out", want.channel_state_out, m_axis_tdata[29:27]);
          check_field("retry_out", want.retry_out, m_axis_tdata[37:30]);
          check_field("window_closed", want.window_closed, m_axis_tdata[38]);
          check_field("intr_conf_pending", want.intr_conf_pending, m_axis_tdata[39]);
          check_field("reset_pending", want.reset_pending, m_axis_tdata[40]);
        end
      end
    end
  end

  // Result side stalls: four random ready modes, each held for a random span
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 120);
    end else rx_left--;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom);
      2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ((rx_tick % 16) < 3);
    endcase
  end

  // Item builders; fields the block ignores get random values
  function automatic chan_item_t pkt_item(input logic [3:0] kind, input logic tmpl);
    chan_item_t it;
    it.req_type      = 1'b0;
    it.packet_type   = kind;
    it.from_template = tmpl;
    it.new_state     = 3'($urandom);
    it.peer_busy     = 1'($urandom);
    it.peer_window   = 3'($urandom);
    return it;
  endfunction

  function automatic chan_item_t upd_item(input logic [2:0] st, input logic busy,
                                          input logic [2:0] win_edge);
    chan_item_t it;
    it.req_type      = 1'b1;
    it.packet_type   = 4'($urandom);
    it.from_template = 1'($urandom);
    it.new_state     = st;
    it.peer_busy     = busy;
    it.peer_window   = win_edge;
    return it;
  endfunction

  // Send one item; bursts of random length separated by random gaps
  task automatic send_item(input chan_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tdata  <= {4'b0, it.peer_window, it.peer_busy, it.new_state,
                      it.from_template, it.packet_type};
    s_axis_tuser  <= it.req_type;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_access(input logic wr, input reg_idx_e idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] cfg_value(input reg_idx_e idx);
    case (idx)
      REG_WINDOW_SIZE: return {29'b0, cfg_window};
      REG_CALL_TIMER:  return {16'b0, cfg_call};
      REG_CLEAR_TIMER: return {16'b0, cfg_clear};
      default:         return {16'b0, cfg_restart};
    endcase
  endfunction

  task automatic check_reg(input reg_idx_e idx);
    logic [31:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== cfg_value(idx)) begin
      $display("%0t: register %s readback, expected %0d, actual %0d",
               $time, idx.name(), cfg_value(idx), rd);
      fail_count++;
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    case (idx)
      REG_WINDOW_SIZE: cfg_window  = value[2:0];
      REG_CALL_TIMER:  cfg_call    = value[15:0];
      REG_CLEAR_TIMER: cfg_clear   = value[15:0];
      default:         cfg_restart = value[15:0];
    endcase
    check_reg(idx);
  endtask

  task automatic apply_settings(input logic [2:0] win, input logic [15:0] t_call,
                                input logic [15:0] t_clear, input logic [15:0] t_restart);
    write_reg(REG_WINDOW_SIZE, {29'b0, win});
    write_reg(REG_CALL_TIMER, {16'b0, t_call});
    write_reg(REG_CLEAR_TIMER, {16'b0, t_clear});
    write_reg(REG_RESTART_TIMER, {16'b0, t_restart});
    settings_used++;
  endtask

  // Register reset values, extremes, readback
  task automatic test_register_access();
    for (int i = 0; i < 4; i++) check_reg(reg_idx_e'(i));
    apply_settings(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    apply_settings(3'd0, 16'h0000, 16'h0000, 16'h0000);
    apply_settings(WINDOW_SIZE_RST, CALL_TIMER_RST, CLEAR_TIMER_RST, RESTART_TIMER_RST);
  endtask

  // Every packet type, held and dropped cases, bad update state
  task automatic test_directed_sequence();
    send_item(pkt_item(PKT_CLEARCONF, 1'b0));      // idle channel, confirm accepted
    send_item(pkt_item(PKT_RESTART, 1'b0));        // restart timer load
    send_item(pkt_item(PKT_RESTARTCONF, 1'b0));
    send_item(pkt_item(PKT_DATA, 1'b0));           // no data outside data transfer
    send_item(pkt_item(PKT_SPARE_A, 1'b1));        // unassigned codes drop
    send_item(pkt_item(PKT_SPARE_B, 1'b0));
    send_item(pkt_item(PKT_OTHER, 1'b1));
    send_item(pkt_item(PKT_CALL, 1'b0));           // call timer load
    send_item(upd_item(CS_BAD_HI, 1'b0, 3'd0));    // state must not change
    send_item(upd_item(CS_RCALL, 1'b0, 3'd0));
    send_item(pkt_item(PKT_ACCEPTED, 1'b0));
    send_item(pkt_item(PKT_DATA, 1'b0));
    send_item(pkt_item(PKT_DATA, 1'b0));           // window of two closes here
    send_item(pkt_item(PKT_DATA, 1'b0));           // held on closed window
    send_item(pkt_item(PKT_RR, 1'b1));             // template bypasses the hold
    send_item(upd_item(CS_DATA, 1'b1, 3'd7));      // reopen window, peer busy
    send_item(pkt_item(PKT_RNR, 1'b0));            // held on busy peer
    send_item(pkt_item(PKT_RNR, 1'b1));
    send_item(upd_item(CS_DATA, 1'b0, 3'd2));
    send_item(pkt_item(PKT_INTR, 1'b0));
    send_item(pkt_item(PKT_INTRCONF, 1'b0));
    send_item(pkt_item(PKT_RESET, 1'b0));
    send_item(pkt_item(PKT_DATA, 1'b0));           // held on pending reset
    send_item(pkt_item(PKT_RESETCONF, 1'b1));
    send_item(pkt_item(PKT_CLEAR, 1'b0));
    send_item(pkt_item(PKT_CLEAR, 1'b1));          // retry count bump
    send_item(pkt_item(PKT_CLEARCONF, 1'b0));
    send_item(upd_item(CS_BAD_LO, 1'b0, 3'd7));
  endtask

  // Clear retries pinned at the top of the counter
  task automatic test_retry_saturation();
    send_item(upd_item(CS_DATA, 1'b0, 3'($urandom)));
    repeat (262) send_item(pkt_item(PKT_CLEAR, 1'b1));
    send_item(pkt_item(PKT_CLEARCONF, 1'b1));
  endtask

  // One call: set up, traffic in data transfer, then a tear down in three of four cases
  task automatic run_session();
    int  pick;
    case ($urandom_range(0, 2))
      0: send_item(upd_item(CS_DATA, 1'b0, 3'($urandom)));
      1: begin
        send_item(upd_item(CS_RCALL, 1'b0, 3'($urandom)));
        send_item(pkt_item(PKT_ACCEPTED, 1'($urandom)));
      end
      default: begin
        send_item(upd_item(CS_READY, 1'b0, 3'($urandom)));
        send_item(pkt_item(PKT_CALL, 1'($urandom)));
        send_item(upd_item(CS_DATA, 1'b0, 3'($urandom)));
      end
    endcase
    repeat ($urandom_range(2, 24)) begin
      pick = $urandom_range(0, 15);
      if (pick < 6) send_item(pkt_item(PKT_DATA, ($urandom_range(0, 3) == 0)));
      else if (pick < 8) send_item(pkt_item(PKT_RR, 1'($urandom)));
      else if (pick == 8) send_item(pkt_item(PKT_RNR, 1'($urandom)));
      else if (pick == 9) send_item(pkt_item(PKT_INTR, 1'($urandom)));
      else if (pick == 10) send_item(pkt_item(PKT_INTRCONF, 1'($urandom)));
      else if (pick == 11) begin
        send_item(pkt_item(PKT_RESET, 1'($urandom)));
        if ($urandom_range(0, 1)) send_item(pkt_item(PKT_DATA, 1'b0));
        send_item(pkt_item(PKT_RESETCONF, 1'b1));
      end else if (pick < 15) begin
        send_item(upd_item(CS_DATA, ($urandom_range(0, 4) == 0), 3'($urandom)));
      end else send_item(pkt_item(4'($urandom), 1'($urandom)));
    end
    case ($urandom_range(0, 3))
      0: begin
        send_item(pkt_item(PKT_CLEAR, 1'($urandom)));
        repeat ($urandom_range(0, 3)) send_item(pkt_item(PKT_CLEAR, 1'b1));
        send_item(pkt_item(PKT_CLEARCONF, 1'b1));
      end
      1: begin
        send_item(upd_item(CS_RCLEAR, 1'b0, 3'($urandom)));
        send_item(pkt_item(PKT_CLEARCONF, 1'($urandom)));
      end
      2: begin
        send_item(upd_item(CS_READY, 1'b0, 3'($urandom)));
        send_item(pkt_item(PKT_RESTART, 1'($urandom)));
        send_item(pkt_item(PKT_RESTARTCONF, 1'($urandom)));
      end
      default: ;
    endcase
  endtask

  // Mostly sessions, some fully random items; one full drain midway
  task automatic run_channel_traffic(input int count);
    int         start;
    bit         paused;
    chan_item_t junk;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < count) begin
      if (!paused && items_sent - start >= count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) run_session();
      else begin
        repeat ($urandom_range(1, 6)) begin
          junk = chan_item_t'($bits(chan_item_t)'($urandom));
          send_item(junk);
        end
      end
    end
  endtask

  // Random traffic under several register settings, extremes included
  task automatic test_config_sweep();
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: apply_settings(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: apply_settings(3'd0, 16'h0000, 16'h0000, 16'h0000);
        2: apply_settings(3'd1, 16'($urandom), 16'($urandom), 16'($urandom));
        3: apply_settings(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: apply_settings(WINDOW_SIZE_RST, 16'($urandom), 16'($urandom),
                                16'($urandom));
      endcase
      run_channel_traffic(85);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_directed_sequence();
    test_retry_saturation();
    test_config_sweep();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Run: %0d items sent, %0d results checked, %0d register settings applied.",
             items_sent, results_checked, settings_used);
    $display("Phases: register access, directed packet types, retry saturation, sweep.");
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #LIMIT_TICKS;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
